>>> hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef logic [31:0] word_t;
    typedef word_t state_t [8];

    // Control from the top level to the compression core.
    typedef struct packed {
        logic start;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    function automatic word_t rotr(word_t x, int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

>>> hw/rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds, one per cycle, on a 16-word schedule window.
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::core_ctl_t ctl,
    input  sha256_pkg::word_t     blk_word [16],
    input  sha256_pkg::state_t    cv_in,
    output sha256_pkg::state_t    cv_out,
    output sha256_pkg::core_sts_t sts
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [5:0]         rnd_reg, rnd_next;
    sha256_pkg::word_t  w_reg [16];
    sha256_pkg::word_t  v_reg [8];
    sha256_pkg::word_t  t1, t2, w_new;
    logic               last_rnd;

    assign last_rnd = (rnd_reg == 6'd63);

    always_comb begin
        t1 = v_reg[7] + sha256_pkg::bsig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::ROUND_K[rnd_reg] + w_reg[0];
        t2 = sha256_pkg::bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = sha256_pkg::ssig1(w_reg[14]) + w_reg[9]
              + sha256_pkg::ssig0(w_reg[1]) + w_reg[0];
        busy_next = busy_reg;
        done_next = 1'b0;
        rnd_next  = rnd_reg;
        if (ctl.start && !busy_reg) begin
            busy_next = 1'b1;
            rnd_next  = '0;
        end else if (busy_reg) begin
            rnd_next = rnd_reg + 6'd1;
            if (last_rnd) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    // The window shifts by one word each round; w_reg[0] is the round word.
    always_ff @(posedge aclk) begin
        if (ctl.start && !busy_reg) begin
            w_reg <= blk_word;
            v_reg <= cv_in;
        end else if (busy_reg) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign cv_out   = v_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// A block compression holds s_ready low through its buffer read, chaining read,
// round and add-back steps. A finish beat pads the block, plus a second block when
// the length no longer fits, then gives eight result beats, one per cycle while m_ready is high.
// After the last result beat the chaining words are restored before s_ready returns.
// Reset is synchronous, active low, restores the initial state; s_ready rises after the restore sweep.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with a block buffer memory and a chaining memory.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PAD   = 4'd1;  // write pad/zero/length bytes
    localparam logic [3:0] ST_LOAD  = 4'd2;  // read 16 words from buffer
    localparam logic [3:0] ST_CVRD  = 4'd3;  // read chaining words
    localparam logic [3:0] ST_RUN   = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;  // read-modify-write chaining
    localparam logic [3:0] ST_OUT   = 4'd6;
    localparam logic [3:0] ST_CLR   = 4'd7;  // restore chaining after finish or reset

    logic [3:0]  st_reg, st_next;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic        fin_reg;      // current compression belongs to a finish
    logic        second_reg;   // a length-only block still follows
    logic [5:0]  pidx_reg;     // pad write pointer
    logic [4:0]  cnt_reg;      // sweep counter
    logic [3:0]  oidx_reg;

    // Block buffer: 16 words of four bytes, byte write enables.
    logic [31:0] buf_mem [16];
    logic [31:0] buf_rd;
    logic [3:0]  buf_raddr;
    logic        buf_we;
    logic [5:0]  buf_waddr;
    logic [7:0]  buf_wdata;

    // Chaining memory: 8 words, reset by a write sweep.
    logic [31:0] cv_mem [8];
    logic [31:0] cv_rd;
    logic [2:0]  cv_raddr;
    logic        cv_we;
    logic [2:0]  cv_waddr;
    logic [31:0] cv_wdata;

    sha256_pkg::word_t     blk_word [16];
    sha256_pkg::state_t    cv_hold;
    sha256_pkg::state_t    cv_out;
    sha256_pkg::core_ctl_t core_ctl;
    sha256_pkg::core_sts_t core_sts;

    logic        absorb_go;
    logic        out_adv;
    logic [7:0]  pad_byte;
    logic [5:0]  pad_last;

    assign s_ready   = (st_reg == ST_IDLE);
    assign absorb_go = s_valid && s_ready && !s_action;

    // Pad byte for position pidx: 0x80 at the fill point, length at the tail of the last block.
    always_comb begin
        pad_byte = 8'h00;
        if (pidx_reg == fill_reg) pad_byte = sha256_pkg::PAD_BYTE;
        if (pidx_reg >= sha256_pkg::LEN_START && !second_reg) begin
            pad_byte = bits_reg[8'(7'd63 - {pidx_reg[2:0], 3'b000}) -: 8];
        end
    end
    assign pad_last = 6'd63;

    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = fill_reg;
        buf_wdata = s_data_byte;
        if (absorb_go) begin
            buf_we = 1'b1;
        end else if (st_reg == ST_PAD) begin
            buf_we    = 1'b1;
            buf_waddr = pidx_reg;
            buf_wdata = pad_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) buf_mem[buf_waddr[5:2]][8'(5'd31 - {buf_waddr[1:0], 3'b000}) -: 8]
            <= buf_wdata;
        buf_rd <= buf_mem[buf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cv_we) cv_mem[cv_waddr] <= cv_wdata;
        cv_rd <= cv_mem[cv_raddr];
    end

    // While results go out, the memory reads the word that the next beat presents.
    assign out_adv   = (oidx_reg == 4'd0) || m_ready;
    assign buf_raddr = cnt_reg[3:0];
    assign cv_raddr  = (st_reg == ST_OUT) ?
                       (out_adv ? oidx_reg[2:0] + 3'd1 : oidx_reg[2:0]) : cnt_reg[2:0];

    always_comb begin
        cv_we    = 1'b0;
        cv_waddr = cnt_reg[2:0];
        cv_wdata = cv_rd + cv_out[cnt_reg[2:0]];
        if (!aresetn || st_reg == ST_CLR) begin
            cv_we    = 1'b1;
            cv_wdata = sha256_pkg::INIT_HASH[cnt_reg[2:0]];
        end else if (st_reg == ST_ADD && cnt_reg != 5'd0) begin
            cv_we    = 1'b1;
            cv_waddr = 3'(cnt_reg - 5'd1);
            cv_wdata = cv_rd + cv_out[3'(cnt_reg - 5'd1)];
        end
    end

    assign core_ctl.start = (st_reg == ST_CVRD) && (cnt_reg == 5'd9);

    sha256_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (core_ctl),
        .blk_word (blk_word),
        .cv_in    (cv_hold),
        .cv_out   (cv_out),
        .sts      (core_sts)
    );

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_action) st_next = ST_PAD;
                else if (absorb_go && fill_reg == 6'd63) st_next = ST_LOAD;
            end
            ST_PAD:  if (pidx_reg == pad_last) st_next = ST_LOAD;
            ST_LOAD: if (cnt_reg == 5'd16) st_next = ST_CVRD;
            ST_CVRD: if (cnt_reg == 5'd9) st_next = ST_RUN;
            ST_RUN:  if (core_sts.done) st_next = ST_ADD;
            ST_ADD: begin
                if (cnt_reg == 5'd8) begin
                    if (!fin_reg) st_next = ST_IDLE;
                    else if (second_reg) st_next = ST_PAD;
                    else st_next = ST_OUT;
                end
            end
            ST_OUT:  if (m_ready && oidx_reg == 4'd8) st_next = ST_CLR;
            ST_CLR:  if (cnt_reg == 5'd7) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_CLR;
            fill_reg   <= '0;
            bits_reg   <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            pidx_reg   <= '0;
            cnt_reg    <= '0;
            oidx_reg   <= '0;
        end else begin
            st_reg <= st_next;
            if (st_next != st_reg) cnt_reg <= '0;
            else cnt_reg <= cnt_reg + 5'd1;
            unique case (st_reg)
                ST_IDLE: begin
                    if (absorb_go) begin
                        fill_reg <= fill_reg + 6'd1;
                        bits_reg <= bits_reg + 64'd8;
                    end else if (s_valid && s_action) begin
                        fin_reg    <= 1'b1;
                        second_reg <= (fill_reg >= sha256_pkg::LEN_START);
                        pidx_reg   <= fill_reg;
                    end
                end
                ST_PAD:  pidx_reg <= pidx_reg + 6'd1;
                ST_ADD: begin
                    if (cnt_reg == 5'd8 && fin_reg && second_reg) begin
                        second_reg <= 1'b0;
                        pidx_reg   <= '0;
                        // the length bytes cover the fill point on this block
                    end
                end
                ST_OUT: begin
                    if (oidx_reg == 4'd0) oidx_reg <= 4'd1;
                    else if (m_ready) oidx_reg <= oidx_reg + 4'd1;
                end
                ST_CLR: begin
                    fill_reg <= '0;
                    bits_reg <= '0;
                    fin_reg  <= 1'b0;
                    oidx_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Sweep captures: each buffer word is registered in buf_rd and then captured into blk_word.
    always_ff @(posedge aclk) begin
        if (st_reg == ST_LOAD && cnt_reg != 5'd0) blk_word[4'(cnt_reg - 5'd1)] <= buf_rd;
        if (st_reg == ST_CVRD && cnt_reg != 5'd0 && cnt_reg <= 5'd8)
            cv_hold[3'(cnt_reg - 5'd1)] <= cv_rd;
        if (st_reg == ST_OUT) begin
            if (oidx_reg == 4'd0 || m_ready) m_digest_word <= cv_rd;
            if (oidx_reg == 4'd0 || m_ready) m_word_index <= oidx_reg[2:0];
        end
    end

    assign m_valid     = (st_reg == ST_OUT) && (oidx_reg != 4'd0);
    assign m_last_word = (m_word_index == 3'd7);

    // On the second block of a two-block finish the fill point lies in the
    // length field, so the length bytes overwrite the 0x80 written there.

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !core_sts.busy)
        else $error("input ready while compression runs");
    a_out_only_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> fin_reg)
        else $error("result beat outside a finish");
    a_start_once: assert property (@(posedge aclk) disable iff (!aresetn)
        core_ctl.start |=> core_sts.busy)
        else $error("core did not start");

endmodule

>>> tb/sha256_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte and finish beats with random gaps and checks every digest word
// against a SHA-256 predictor, with known first digest words typed into the directed table.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    typedef struct {
        logic        act;
        logic [7:0]  data;
        logic        known;
        logic [31:0] w0;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    // Predictor state.
    logic [31:0] hash_h [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] nbits;

    digest_beat_t digest_q [$];
    int errors = 0;
    int beats_in = 0;
    int words_out = 0;
    int messages = 0;
    int cycles = 0;
    int hold_off = 0;
    int rx_wait = 0;
    bit long_hold = 0;

    sha256_stream_hasher uut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sha256_stream_hasher regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++) hash_h[i] = sha256_pkg::INIT_HASH[i];
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        fill = '0;
        nbits = '0;
    endtask

    // Advances the predictor by one accepted beat and queues any digest words.
    task automatic hash_step(logic act, logic [7:0] data);
        digest_beat_t b;
        if (act == ACT_ABSORB) begin
            blk[fill] = data;
            nbits += 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0) compress();
        end else begin
            for (int i = fill; i < 64; i++) blk[i] = 8'h00;
            blk[fill] = sha256_pkg::PAD_BYTE;
            if (fill >= sha256_pkg::LEN_START) begin
                compress();
                for (int i = 0; i < 64; i++) blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                b.word = hash_h[i];
                b.index = 3'(i);
                b.last = (i == 7);
                digest_q.push_back(b);
            end
            hash_restart();
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Result side: a drawn wait after each accepted beat, plus one long hold-off on its own counter.
    always @(posedge aclk) begin
        digest_beat_t e;
        int w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                words_out++;
                if (digest_q.size() == 0) begin
                    report("unexpected word", m_digest_word, 32'h0);
                end else begin
                    e = digest_q.pop_front();
                    if (m_digest_word !== e.word) report("digest_word", m_digest_word, e.word);
                    if (m_word_index !== e.index)
                        report("word_index", 32'(m_word_index), 32'(e.index));
                    if (m_last_word !== e.last)
                        report("last_word", 32'(m_last_word), 32'(e.last));
                end
            end
            if (long_hold) begin
                m_ready <= 1'b0;
                long_hold <= 1'b0;
                hold_off <= 600;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= (hold_off == 1);
            end else if (m_valid && m_ready) begin
                w = $urandom_range(0, 12);
                rx_wait <= w;
                m_ready <= (w == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_ready <= (rx_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send(logic act, logic [7:0] data, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        hash_step(act, data);
        beats_in++;
        if (act == ACT_FINISH) messages++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    stim_row_t dir [$];
    int n;
    logic [31:0] want0;

    initial begin
        hash_restart();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, "abc", extreme bytes; the 55/56/63/64 byte tails
        // follow in a loop below.
        dir.push_back('{ACT_FINISH, 8'hff, 1'b1, 32'he3b0c442});
        dir.push_back('{ACT_ABSORB, 8'h61, 1'b0, 32'h0});
        dir.push_back('{ACT_ABSORB, 8'h62, 1'b0, 32'h0});
        dir.push_back('{ACT_ABSORB, 8'h63, 1'b0, 32'h0});
        dir.push_back('{ACT_FINISH, 8'h00, 1'b1, 32'hba7816bf});
        dir.push_back('{ACT_ABSORB, 8'h00, 1'b0, 32'h0});
        dir.push_back('{ACT_FINISH, 8'h00, 1'b0, 32'h0});
        dir.push_back('{ACT_ABSORB, 8'hff, 1'b0, 32'h0});
        dir.push_back('{ACT_FINISH, 8'h5a, 1'b0, 32'h0});
        dir.push_back('{ACT_FINISH, 8'h00, 1'b1, 32'he3b0c442});
        foreach (dir[i]) begin
            if (dir[i].act == ACT_FINISH && dir[i].known) begin
                want0 = dir[i].w0;
                send(dir[i].act, dir[i].data, $urandom_range(0, 12));
                if (digest_q[0].word !== want0) report("known digest", digest_q[0].word, want0);
            end else begin
                send(dir[i].act, dir[i].data, $urandom_range(0, 12));
            end
        end
        // Tails of 55, 56, 63 and 64 bytes around the length field boundary.
        for (int k = 0; k < 4; k++) begin
            n = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : 64;
            for (int j = 0; j < n; j++) send(ACT_ABSORB, 8'(j * 37), 0);
            send(ACT_FINISH, 8'h00, 0);
        end

        // Long receiver hold-off while bytes keep coming.
        long_hold <= 1'b1;
        for (int j = 0; j < 3; j++) begin
            n = $urandom_range(0, 6);
            for (int b = 0; b < n; b++) send(ACT_ABSORB, 8'($urandom), 0);
            send(ACT_FINISH, 8'($urandom), 0);
        end
        drain();

        // Random messages of mostly small lengths, a few spanning blocks.
        while (beats_in < 285) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
            if (n > 284 - beats_in) n = 284 - beats_in;
            for (int b = 0; b < n; b++)
                send(ACT_ABSORB, 8'($urandom), $urandom_range(0, 3) == 0 ? 0 :
                     $urandom_range(0, 12));
            send(ACT_FINISH, 8'($urandom), $urandom_range(0, 12));
            if ($urandom_range(0, 5) == 0) drain();
        end

        drain();
        repeat (200) @(posedge aclk);
        $display("covered %0d input beats, %0d messages, %0d digest words checked",
                 beats_in, messages, words_out);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("sha256_stream_hasher regression: pass");
        end else begin
            $display("%0d mismatches, %0d words outstanding", errors, digest_q.size());
            $display("sha256_stream_hasher regression: fail");
        end
        $finish;
    end
endmodule
